// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the receiver's RTL files.
// Depends on a clk_i clock and an active-low rst_ni reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SWHR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define SWHR_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hdl/swhr_pkg.sv =====
// Types, constants and compare helpers for the single-wire humidity receiver.
// No dependencies; used by every module of the block.
package swhr_pkg;

  localparam int TimeBits   = 32;
  localparam int RegBits    = 16;
  localparam int NumRegs    = 8;
  localparam int RegIdxBits = 4;
  localparam int QueueDepth = 4;
  localparam int QPtrBits   = $clog2(QueueDepth);
  localparam int QCntBits   = $clog2(QueueDepth + 1);
  localparam int FrameBytes = 5;
  localparam int ByteIdxBits = $clog2(FrameBytes);
  localparam int OutBits    = 24;

  typedef enum logic {
    KindStart = 1'b0,
    KindEdge  = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    PhResponse = 2'd0,
    PhData     = 2'd1,
    PhAcquired = 2'd2,
    PhStopped  = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    StOk         = 3'd0,
    StNotStarted = 3'd1,
    StChecksum   = 3'd2,
    StTimeout    = 3'd3,
    StResponse   = 3'd4,
    StData       = 3'd5,
    StDelta      = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    RegGapTimeout  = 3'd0,
    RegGlitchLimit = 3'd1,
    RegRespLow     = 3'd2,
    RegRespHigh    = 3'd3,
    RegTooShort    = 3'd4,
    RegBitLow      = 3'd5,
    RegBitHigh     = 3'd6,
    RegOneThresh   = 3'd7
  } reg_e;

  localparam logic [RegBits-1:0] RegReset [NumRegs] = '{
    16'd6000, 16'd25, 16'd125, 16'd190, 16'd10, 16'd60, 16'd155, 16'd90
  };

  typedef struct packed {
    kind_e                kind;
    logic [TimeBits-1:0]  time_us;
  } item_t;

  typedef struct packed {
    logic [7:0] temperature;
    logic [7:0] humidity;
    logic       reading_valid;
    logic       busy_res;
    status_e    status;
    logic       start_refused;
  } result_t;

  // Gap is signed: a set sign bit counts as below every bound.
  function automatic logic gap_gt(logic [TimeBits-1:0] gap, logic [RegBits-1:0] th);
    return !gap[TimeBits-1] && (gap > TimeBits'(th));
  endfunction

  function automatic logic gap_lt(logic [TimeBits-1:0] gap, logic [RegBits-1:0] th);
    return gap[TimeBits-1] || (gap < TimeBits'(th));
  endfunction

endpackage

// ===== hdl/swhr_front.sv =====
// Front end: accepts input transfers, classifies them and queues them.
// Depends on swhr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swhr_front import swhr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                in_op_i,
  input  logic [TimeBits-1:0] in_time_i,
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output item_t               q_item_o
);

  item_t                mem_q [QueueDepth];
  logic [QPtrBits-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrBits-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntBits-1:0]  count_q, count_d;
  logic                 push, pop;
  item_t                item;

  always_comb begin
    item.kind    = in_op_i ? KindEdge : KindStart;
    item.time_us = in_time_i;
  end

  assign in_ready_o = (count_q != QCntBits'(QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && q_valid_o;
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + QCntBits'(push) - QCntBits'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `SWHR_ASSERT(a_count_bound, count_q <= QCntBits'(QueueDepth), "queue count overflow")
  `SWHR_ASSERT(a_ptr_gap, QPtrBits'(wr_ptr_q - rd_ptr_q) == QPtrBits'(count_q),
    "queue pointers disagree with count")
  `SWHR_ASSERT_IMPL(a_count_track, $past(push) && !$past(pop),
    count_q == $past(count_q) + 1'b1, "queue count missed a push")

endmodule

// ===== hdl/swhr_back.sv =====
// Back end: frame decoder state, configuration registers and result register.
// Depends on swhr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module swhr_back import swhr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [RegBits-1:0]    cfg_wdata_i,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  item_t                 q_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output result_t               out_data_o
);

  logic [RegBits-1:0]     regs_q [NumRegs];
  phase_e                 phase_q, phase_d;
  status_e                code_q, code_d;
  logic [7:0]             frame_q [FrameBytes];
  logic [7:0]             frame_d [FrameBytes];
  logic [2:0]             bit_pos_q, bit_pos_d;
  logic [2:0]             byte_pos_q, byte_pos_d;
  logic [TimeBits-1:0]    last_q, last_d;
  logic [7:0]             hum_q, hum_d;
  logic [7:0]             temp_q, temp_d;
  logic                   out_valid_q, out_valid_d;
  result_t                out_q, out_d;
  logic [TimeBits-1:0]    gap;
  logic [ByteIdxBits-1:0] idx;
  logic                   refused;
  logic                   pop;

  assign pop     = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o = pop;
  assign gap     = q_item_i.time_us - last_q;
  assign idx     = (byte_pos_q < 3'(FrameBytes)) ? ByteIdxBits'(byte_pos_q)
                                                 : ByteIdxBits'(FrameBytes - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= RegReset[i];
      end
    end else if (cfg_we_i && (cfg_idx_i < RegIdxBits'(NumRegs))) begin
      regs_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    code_d     = code_q;
    frame_d    = frame_q;
    bit_pos_d  = bit_pos_q;
    byte_pos_d = byte_pos_q;
    last_d     = last_q;
    hum_d      = hum_q;
    temp_d     = temp_q;
    refused    = 1'b0;
    if (pop) begin
      if (q_item_i.kind == KindStart) begin
        if (phase_q == PhStopped || phase_q == PhAcquired) begin
          phase_d    = PhResponse;
          for (int i = 0; i < FrameBytes; i++) begin
            frame_d[i] = '0;
          end
          bit_pos_d  = 3'd7;
          byte_pos_d = '0;
          hum_d      = '0;
          temp_d     = '0;
          last_d     = q_item_i.time_us;
        end else begin
          refused = 1'b1;
        end
      end else if (phase_q == PhResponse || phase_q == PhData) begin
        last_d = q_item_i.time_us;
        priority if (gap_gt(gap, regs_q[RegGapTimeout])) begin
          code_d  = StTimeout;
          phase_d = PhStopped;
        end else if (phase_q == PhResponse) begin
          priority if (gap_lt(gap, regs_q[RegGlitchLimit])) begin
            last_d = last_q;  // glitch: keep the reference time
          end else if (gap_gt(gap, regs_q[RegRespLow]) &&
                       gap_lt(gap, regs_q[RegRespHigh])) begin
            phase_d = PhData;
          end else begin
            code_d  = StResponse;
            phase_d = PhStopped;
          end
        end else begin
          priority if (gap_lt(gap, regs_q[RegTooShort])) begin
            code_d  = StDelta;
            phase_d = PhStopped;
          end else if (gap_gt(gap, regs_q[RegBitLow]) &&
                       gap_lt(gap, regs_q[RegBitHigh])) begin
            if (gap_gt(gap, regs_q[RegOneThresh])) begin
              frame_d[idx] = frame_q[idx] | (8'd1 << bit_pos_q);
            end
            if (bit_pos_q == '0) begin
              bit_pos_d = 3'd7;
              if (byte_pos_q >= 3'd4) begin
                byte_pos_d = 3'(FrameBytes);
                hum_d      = frame_d[0];
                temp_d     = frame_d[2];
                if (frame_d[4] != 8'(frame_d[0] + frame_d[2])) begin
                  code_d  = StChecksum;
                  phase_d = PhStopped;
                end else begin
                  code_d  = StOk;
                  phase_d = PhAcquired;
                end
              end else begin
                byte_pos_d = byte_pos_q + 1'b1;
              end
            end else begin
              bit_pos_d = bit_pos_q - 1'b1;
            end
          end else begin
            code_d  = StData;
            phase_d = PhStopped;
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop) begin
      out_valid_d         = 1'b1;
      out_d.start_refused = refused;
      out_d.status        = code_d;
      out_d.busy_res      = (phase_d == PhResponse) || (phase_d == PhData);
      out_d.reading_valid = (phase_d == PhAcquired);
      out_d.humidity      = hum_d;
      out_d.temperature   = temp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhStopped;
      code_q      <= StNotStarted;
      for (int i = 0; i < FrameBytes; i++) begin
        frame_q[i] <= '0;
      end
      bit_pos_q   <= 3'd7;
      byte_pos_q  <= '0;
      last_q      <= '0;
      hum_q       <= '0;
      temp_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      code_q      <= code_d;
      frame_q     <= frame_d;
      bit_pos_q   <= bit_pos_d;
      byte_pos_q  <= byte_pos_d;
      last_q      <= last_d;
      hum_q       <= hum_d;
      temp_q      <= temp_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SWHR_ASSERT(a_byte_pos, byte_pos_q <= 3'(FrameBytes), "byte position out of range")
  `SWHR_ASSERT_IMPL(a_acq_ok, phase_q == PhAcquired, code_q == StOk,
    "acquired phase without ok status")
  `SWHR_ASSERT_IMPL(a_busy_excl, out_valid_q, !(out_q.busy_res && out_q.reading_valid),
    "result both busy and valid")

endmodule

// ===== hdl/single_wire_humidity_sensor_receiver.sv =====
// Top level of the single-wire humidity sensor receiver.
// Depends on swhr_pkg, swhr_front and swhr_back.
//
// Usage:
//   Input stream (s_axis_*): one transfer per item. tuser is the op
//   (0 start acquisition, 1 falling edge seen), tdata the microsecond
//   timestamp of that item. Output stream (m_axis_*): exactly one result
//   transfer per input transfer, in order.
//   Configuration: pulse cfg_we_i with cfg_idx_i/cfg_wdata_i to write one of
//   the eight 16-bit timing registers; indexes above seven are dropped.
//   Write only while no item is in flight.
//   Path: with the queue empty an input transfer is written into the queue,
//   then decoded from the queue head into the result register.
//   Throughput: one item per cycle, set by the decoder update
//   in the back end, which handles the queue head whenever the result
//   register is empty or being taken.
//   Stall: while m_axis_tready is low, the result is held and up to four
//   items gather in the front queue; s_axis_tready then falls.
//   Reset: the queue empties, the registers take their default timings, the
//   decoder is stopped with status "not started" and cleared readings.

module single_wire_humidity_sensor_receiver import swhr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [TimeBits-1:0]   s_axis_tdata,   // [31:0] time_us
  input  logic                  s_axis_tuser,   // [0] op
  // Result stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] start_refused, [3:1] status, [4] busy_res, [5] reading_valid,
  // [13:6] humidity, [21:14] temperature, [23:22] zero
  output logic [OutBits-1:0]    m_axis_tdata,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [RegIdxBits-1:0] cfg_idx_i,
  input  logic [RegBits-1:0]    cfg_wdata_i
);

  logic    q_valid;
  logic    q_pop;
  item_t   q_item;
  result_t res;

  // Accept and classify items into the short queue.
  swhr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_op_i    (s_axis_tuser),
    .in_time_i  (s_axis_tdata),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  // Decode frames and hold the result for the output side.
  swhr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  // Pack fields from the lowest bit up and pad to whole bytes.
  assign m_axis_tdata = {(OutBits - $bits(result_t))'(0), res};

endmodule
